/* design/grid_path_count_no_repeat_move_top_assert.svh */
// Assertion macros shared by the grid path counter checker.
// No dependencies; included by the checker file.
`ifndef GRID_PATH_COUNT_NO_REPEAT_MOVE_TOP_ASSERT_SVH
`define GRID_PATH_COUNT_NO_REPEAT_MOVE_TOP_ASSERT_SVH

// plain implication check with reset qualification
`define GPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// a signal holds its value on the cycle after cond
`define GPC_ASSERT_HOLD(name, clk, rst, cond, sig, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

/* design/gpc_pkg.sv */
// Types, constants and modular add for the grid path counter.
// No dependencies; used by every module of the block.
package gpc_pkg;

   localparam int COUNT_W = 27;

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type PATH_MOD = 27'd100000007;
   // inverse of 2: any two first-column counts add up to one
   localparam count_type HALF_MOD = 27'd50000004;

   // counts of paths ending in a row, split by the move that entered it
   typedef struct packed {
      count_type up;
      count_type level;
      count_type down;
   } counts_type;

   typedef struct packed {
      logic open;
      logic first;
      logic last;
      logic col_end;
      logic below_ok;
   } ctrl_type;

   function automatic count_type add_mod(input count_type a, input count_type b);
      logic [COUNT_W:0] s;
      logic [COUNT_W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, PATH_MOD};
      return (s >= {1'b0, PATH_MOD}) ? d[COUNT_W-1:0] : s[COUNT_W-1:0];
   endfunction

endpackage

/* design/gpc_calc.sv */
// New per-move counts of one cell, the updated column total and the open-cell count.
// Depends on gpc_pkg.
module gpc_calc
   import gpc_pkg::*;
(
   input  ctrl_type   ctrl,
   input  counts_type cur,
   input  counts_type below,
   input  counts_type above,
   input  count_type  total_acc,
   input  logic [9:0] open_count,
   output counts_type new_counts,
   output count_type  total_next,
   output logic [9:0] open_next
);

   counts_type below_m;
   counts_type mid;
   count_type  cell_sum;

   always_comb begin
      below_m = ctrl.below_ok ? below : '0;
      mid.up    = add_mod(below_m.level, below_m.down);
      mid.level = add_mod(cur.up, cur.down);
      mid.down  = add_mod(above.up, above.level);
      cell_sum  = add_mod(mid.up, add_mod(mid.level, mid.down));

      if (!ctrl.open) begin
         new_counts = '0;
      end else if (ctrl.first) begin
         new_counts = '{up: HALF_MOD, level: HALF_MOD, down: HALF_MOD};
      end else begin
         new_counts = mid;
      end

      total_next = (ctrl.open && !ctrl.first) ? add_mod(total_acc, cell_sum) : total_acc;
      open_next  = (ctrl.open && ctrl.first) ? open_count + 10'd1 : open_count;
   end

endmodule

/* design/grid_path_count_no_repeat_move_top.sv */
// Grid path counter, top level. Takes one cell per cycle with no gaps of its own:
// a two-stage pipe where stage one reads the previous column's counts for the
// current row and the row below from a dual-read memory, and stage two forms the
// new counts, writes them back and accumulates. Forwarding covers a write and a
// read of the same row in one cycle. The result is registered as the last cell
// leaves stage two. A result left waiting blocks input only while a second
// last cell sits in stage two. No clearing pass is needed after reset.
// Depends on gpc_pkg and gpc_calc.
module grid_path_count_no_repeat_move_top
   import gpc_pkg::*;
#(
   parameter int MAX_ROWS = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_blocked,
   input  logic             req_last_cell,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [26:0]      rsp_path_count,
   input  logic             csr_wr_en,
   input  logic [9:0]       csr_wr_data
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = (RW + 1 > 10) ? RW + 1 : 10;
   localparam logic [CW-1:0] MaxRowsC = CW'(MAX_ROWS);

   counts_type mem [MAX_ROWS];

   logic [9:0]    num_rows_ff;
   logic [AW-1:0] row_ff, row_in;
   logic          first_ff, first_in;

   logic          s2_v_ff, s2_v_in;
   logic [AW-1:0] s2_row_ff;
   ctrl_type      s2_ctrl_ff;
   counts_type    rd_cur_ff, rd_below_ff;

   counts_type    above_ff, above_in;
   count_type     total_ff, total_in;
   logic [9:0]    open_ff, open_in;
   logic          rsp_valid_ff, rsp_valid_in;
   count_type     rsp_data_ff;

   logic [CW-1:0] rows, nrows_ext, row_plus;
   logic [AW-1:0] below_addr;
   logic          below_ok, col_end, acc1, adv2, fire2, fwd_cur, fwd_below;
   counts_type    new_counts;
   count_type     total_next;
   logic [9:0]    open_next;

   assign nrows_ext  = CW'(num_rows_ff);
   assign rows       = (nrows_ext == '0) ? CW'(1) :
                       (nrows_ext > MaxRowsC) ? MaxRowsC : nrows_ext;
   assign row_plus   = CW'(row_ff) + CW'(1);
   assign below_addr = row_plus[AW-1:0];
   assign below_ok   = row_plus < rows;
   assign col_end    = !below_ok;

   assign adv2      = !(s2_v_ff && s2_ctrl_ff.last && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv2;
   assign acc1      = req_valid && adv2;
   assign fire2     = s2_v_ff && adv2;
   assign fwd_cur   = fire2 && (s2_row_ff == row_ff);
   assign fwd_below = fire2 && (s2_row_ff == below_addr);

   gpc_calc u_calc (
      .ctrl       (s2_ctrl_ff),
      .cur        (rd_cur_ff),
      .below      (rd_below_ff),
      .above      (above_ff),
      .total_acc  (total_ff),
      .open_count (open_ff),
      .new_counts (new_counts),
      .total_next (total_next),
      .open_next  (open_next)
   );

   always_comb begin
      row_in   = row_ff;
      first_in = first_ff;
      if (acc1) begin
         if (req_last_cell) begin
            row_in   = '0;
            first_in = 1'b1;
         end else if (col_end) begin
            row_in   = '0;
            first_in = 1'b0;
         end else begin
            row_in = below_addr;
         end
      end

      s2_v_in = acc1 ? 1'b1 : (fire2 ? 1'b0 : s2_v_ff);

      above_in = above_ff;
      total_in = total_ff;
      open_in  = open_ff;
      if (fire2) begin
         if (s2_ctrl_ff.last || s2_ctrl_ff.col_end) begin
            above_in = '0;
            total_in = '0;
         end else if (!s2_ctrl_ff.first) begin
            above_in = rd_cur_ff;
            total_in = total_next;
         end
         open_in = s2_ctrl_ff.last ? 10'd0 : open_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire2 && s2_ctrl_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // previous column store: two reads, one write, read-first with forwarding
   always_ff @(posedge clock) begin
      if (fire2) begin
         mem[s2_row_ff] <= new_counts;
      end
      if (acc1) begin
         rd_cur_ff   <= fwd_cur ? new_counts : mem[row_ff];
         rd_below_ff <= fwd_below ? new_counts : mem[below_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc1) begin
         s2_row_ff  <= row_ff;
         s2_ctrl_ff <= '{open: !req_blocked, first: first_ff, last: req_last_cell,
                         col_end: col_end, below_ok: below_ok};
      end
      if (fire2 && s2_ctrl_ff.last) begin
         rsp_data_ff <= s2_ctrl_ff.first ? count_type'(open_next) : total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= 10'd1;
         row_ff       <= '0;
         first_ff     <= 1'b1;
         s2_v_ff      <= 1'b0;
         above_ff     <= '0;
         total_ff     <= '0;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            num_rows_ff <= csr_wr_data;
         end
         row_ff       <= row_in;
         first_ff     <= first_in;
         s2_v_ff      <= s2_v_in;
         above_ff     <= above_in;
         total_ff     <= total_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_data_ff;

endmodule

/* design/gpc_checker.sv */
// Port-level checks on the grid path counter, bound to the top level.
// Depends on gpc_pkg and grid_path_count_no_repeat_move_top_assert.svh.
`include "grid_path_count_no_repeat_move_top_assert.svh"

module gpc_checker
   import gpc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_cell,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [26:0] rsp_path_count
);

   logic last_taken;
   logic rsp_held;
   assign last_taken = req_valid && !req_stall && req_last_cell;
   assign rsp_held   = rsp_valid && rsp_stall;

   `GPC_ASSERT(a_rsp_hold_valid, clock, reset, rsp_held |=> rsp_valid, "item dropped")
   `GPC_ASSERT_HOLD(a_rsp_hold_data, clock, reset, rsp_held, rsp_path_count, "item changed")
   `GPC_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_path_count < PATH_MOD, "count too big")
   `GPC_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(last_taken, 2), "no last cell")

endmodule

bind grid_path_count_no_repeat_move_top gpc_checker u_gpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last_cell  (req_last_cell),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_path_count (rsp_path_count)
);

/* verif/grid_path_count_no_repeat_move_checker.sv */
// Checker for the grid path counter: watches the cell, result and register ports,
// predicts the path count of each grid and compares it with the result items.
// Depends on gpc_pkg for the count types and the modulus constants.
module grid_path_count_no_repeat_move_checker
   import gpc_pkg::*;
#(
   parameter int MAX_ROWS = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_blocked,
   input  logic        req_last_cell,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [26:0] rsp_path_count,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [9:0]  rows_cfg;
   counts_type  col_mem [MAX_ROWS];
   int unsigned row_ptr;
   logic        in_first;
   counts_type  win_above;
   counts_type  win_here;
   count_type   col_sum;
   logic [9:0]  opens;
   count_type   expected_totals [$];
   int          mismatches = 0;

   function automatic count_type mod_sum(input count_type a, input count_type b);
      logic [27:0] s;
      s = a + b;
      if (s >= PATH_MOD) s = s - PATH_MOD;
      return s[26:0];
   endfunction

   task automatic restart_grid();
      row_ptr   = 0;
      in_first  = 1'b1;
      win_above = '0;
      win_here  = '0;
      col_sum   = '0;
      opens     = '0;
   endtask

   task automatic count_cell(input logic blk, input logic lst);
      int unsigned rows;
      int unsigned r;
      counts_type  fresh;
      counts_type  below;
      rows  = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg);
      r     = row_ptr % MAX_ROWS;
      fresh = '0;
      below = '0;
      if (in_first) begin
         if (!blk) begin
            fresh = '{HALF_MOD, HALF_MOD, HALF_MOD};
            opens = opens + 10'd1;
         end
      end else begin
         if (r + 1 < rows) below = col_mem[r + 1];
         win_here = col_mem[r];
         if (!blk) begin
            fresh.up    = mod_sum(below.level, below.down);
            fresh.level = mod_sum(win_here.up, win_here.down);
            fresh.down  = mod_sum(win_above.up, win_above.level);
            col_sum = mod_sum(col_sum, mod_sum(fresh.up, mod_sum(fresh.level, fresh.down)));
         end
         win_above = win_here;
      end
      col_mem[r] = fresh;
      if (lst) begin
         expected_totals.push_back(in_first ? count_type'(opens) : col_sum);
         restart_grid();
      end else if (r + 1 >= rows) begin
         row_ptr   = 0;
         in_first  = 1'b0;
         col_sum   = '0;
         win_above = '0;
         win_here  = '0;
      end else begin
         row_ptr = r + 1;
      end
   endtask

   always @(posedge clock) begin
      count_type want;
      if (reset) begin
         rows_cfg = 10'd1;
         restart_grid();
         expected_totals.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               $display("%0t: path count %0d with no grid outstanding", $time, rsp_path_count);
               mismatches++;
            end else begin
               want = expected_totals.pop_front();
               if (rsp_path_count !== want) begin
                  $display("%0t: path_count expected %0d actual %0d", $time, want,
                           rsp_path_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) count_cell(req_blocked, req_last_cell);
         if (csr_wr_en) rows_cfg = csr_wr_data;
      end
      pending    <= expected_totals.size();
      fail_count <= mismatches;
   end

endmodule

/* verif/grid_path_count_no_repeat_move_top_tb.sv */
// Testbench top for the grid path counter: clock, reset, cell and register stimulus
// with random idling on both channels, and the final verdict.
// Depends on gpc_pkg, the block and grid_path_count_no_repeat_move_checker.
module grid_path_count_no_repeat_move_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gpc_pkg::*;

   localparam int MAX_ROWS  = 512;
   localparam int CYCLE_CAP = 200000;
   localparam int SETTLE    = 10;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_blocked   = 1'b0;
   logic        req_last_cell = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [26:0] rsp_path_count;
   logic        csr_wr_en     = 1'b0;
   logic [9:0]  csr_wr_data   = '0;

   int fail_count;
   int pending;
   int cycles  = 0;
   int sent    = 0;
   int tx_idle = 6;
   int rx_idle = 52;

   grid_path_count_no_repeat_move_top #(
      .MAX_ROWS(MAX_ROWS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_blocked   (req_blocked),
      .req_last_cell (req_last_cell),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_path_count(rsp_path_count),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   grid_path_count_no_repeat_move_checker #(
      .MAX_ROWS(MAX_ROWS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_blocked   (req_blocked),
      .req_last_cell (req_last_cell),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_path_count(rsp_path_count),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("[grid_path_count_no_repeat_move_top] ERROR");
         $finish;
      end
   end

   task automatic send_cell(input logic blk, input logic lst);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_blocked   <= blk;
      req_last_cell <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rows(input logic [9:0] value);
      settle();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // full columns, then an optional partial column that ends the grid early
   task automatic run_grid(input int rows, input int full_cols, input int tail,
                           input int open_pct);
      int total;
      total = full_cols * rows + tail;
      for (int i = 0; i < total; i++)
         send_cell($urandom_range(99) >= open_pct, i == total - 1);
   endtask

   initial begin
      int row_settings [11] = '{2, 0, 5, 1, 512, 3, 16, 1023, 4, 7, 9};
      int rows_eff;
      int budget;
      int cols;
      int kind;
      int open_pct;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // one row from reset: lone open cell, lone blocked cell, three columns
      send_cell(1'b0, 1'b1);
      send_cell(1'b1, 1'b1);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);
      write_rows(10'd3);
      run_grid(3, 3, 0, 100);
      // early end in the first column, then in the second
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b1);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b0, 1'b1);

      for (int p = 0; p < 11; p++) begin
         write_rows(10'(row_settings[p]));
         case (p * 3 / 11)
            0: begin
               tx_idle = 6;
               rx_idle = 52;
            end
            1: begin
               tx_idle = 52;
               rx_idle = 6;
            end
            default: begin
               tx_idle = 0;
               rx_idle = 0;
            end
         endcase
         rows_eff = (row_settings[p] == 0) ? 1 :
                    ((row_settings[p] > MAX_ROWS) ? MAX_ROWS : row_settings[p]);
         if (rows_eff == MAX_ROWS) begin
            run_grid(rows_eff, 1, $urandom_range(1, 20), 90);
            run_grid(rows_eff, 0, $urandom_range(1, 30), 70);
         end else begin
            budget = sent + 70;
            while (sent < budget) begin
               kind     = $urandom_range(9);
               open_pct = (kind < 3) ? 100 : $urandom_range(100);
               cols     = $urandom_range(1, (rows_eff <= 4) ? 30 : 120 / rows_eff);
               if (kind >= 8)
                  run_grid(rows_eff, cols - 1, $urandom_range(1, rows_eff), open_pct);
               else
                  run_grid(rows_eff, cols, 0, open_pct);
            end
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("[grid_path_count_no_repeat_move_top] OK");
      end else begin
         $display("[grid_path_count_no_repeat_move_top] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/gpc_pkg.sv
design/gpc_calc.sv
design/grid_path_count_no_repeat_move_top.sv
design/gpc_checker.sv
verif/grid_path_count_no_repeat_move_checker.sv
verif/grid_path_count_no_repeat_move_top_tb.sv
